FILE: rtl/fcrs_pkg.sv
// fcrs_pkg: shared types and constants for the configuration restart sequencer
// holds the phase enum, the result record, register indexes and reset values
// no dependencies
package fcrs_pkg;

    localparam int TIMER_BITS_DEF = 13;
    localparam int LIMIT_W        = 13;
    localparam int TICKS_W        = 10;
    localparam int COUNT_W        = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 13;

    localparam logic [LIMIT_W-1:0] INIT_WAIT_RST  = 13'd500;
    localparam logic [LIMIT_W-1:0] DONE_WAIT_RST  = 13'd5000;
    localparam logic [COUNT_W-1:0] ATTEMPT_RST    = 4'd3;
    localparam logic [TICKS_W-1:0] HOLD_RST       = 10'd10;
    localparam logic [TICKS_W-1:0] PRE_SETTLE_RST = 10'd100;
    localparam logic [TICKS_W-1:0] DONE_SETTLE_RST = 10'd100;
    localparam logic [TICKS_W-1:0] BACKOFF_RST    = 10'd250;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INIT_WAIT   = 3'd0,
        REG_DONE_WAIT   = 3'd1,
        REG_ATTEMPTS    = 3'd2,
        REG_HOLD        = 3'd3,
        REG_PRE_SETTLE  = 3'd4,
        REG_DONE_SETTLE = 3'd5,
        REG_BACKOFF     = 3'd6
    } cfg_reg_t;

    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_SETTLE      = 4'd1,
        PH_RESET_WAIT  = 4'd2,
        PH_WAIT_INIT   = 4'd3,
        PH_WAIT_DONE   = 4'd4,
        PH_INIT_TO     = 4'd5,
        PH_DONE_TO     = 4'd6,
        PH_SUCCESS     = 4'd7,
        PH_SETUP_ERR   = 4'd8,
        PH_HOLD        = 4'd9,
        PH_DONE_SETTLE = 4'd10,
        PH_FAIL_INIT   = 4'd11,
        PH_FAIL_DONE   = 4'd12
    } phase_t;

    typedef enum logic [3:0] {
        CODE_IDLE      = 4'd0,
        CODE_SETTLE    = 4'd1,
        CODE_RESET     = 4'd2,
        CODE_WAIT_INIT = 4'd3,
        CODE_WAIT_DONE = 4'd4,
        CODE_INIT_TO   = 4'd5,
        CODE_DONE_TO   = 4'd6,
        CODE_SUCCESS   = 4'd7,
        CODE_SETUP_ERR = 4'd8
    } phase_code_t;

    typedef enum logic [1:0] {
        OUT_RUNNING   = 2'd0,
        OUT_SUCCESS   = 2'd1,
        OUT_SETUP_ERR = 2'd2,
        OUT_TIMEOUT   = 2'd3
    } outcome_t;

    typedef enum logic {
        REQ_TICK  = 1'b0,
        REQ_START = 1'b1
    } req_t;

    typedef struct packed {
        logic               program_asserted;
        logic               mux_on;
        logic [3:0]         phase_code;
        logic [COUNT_W-1:0] attempts_used;
        logic [COUNT_W-1:0] init_low_count;
        logic [1:0]         outcome;
    } result_t;

    // hold and done settle report as the phase they belong to
    function automatic phase_code_t phase_to_code(input phase_t ph);
        phase_code_t code;
        begin
            unique case (ph)
                PH_IDLE:        code = CODE_IDLE;
                PH_SETTLE:      code = CODE_SETTLE;
                PH_RESET_WAIT:  code = CODE_RESET;
                PH_HOLD:        code = CODE_RESET;
                PH_WAIT_INIT:   code = CODE_WAIT_INIT;
                PH_WAIT_DONE:   code = CODE_WAIT_DONE;
                PH_DONE_SETTLE: code = CODE_WAIT_DONE;
                PH_INIT_TO:     code = CODE_INIT_TO;
                PH_FAIL_INIT:   code = CODE_INIT_TO;
                PH_DONE_TO:     code = CODE_DONE_TO;
                PH_FAIL_DONE:   code = CODE_DONE_TO;
                PH_SUCCESS:     code = CODE_SUCCESS;
                PH_SETUP_ERR:   code = CODE_SETUP_ERR;
                default:        code = CODE_IDLE;
            endcase
            return code;
        end
    endfunction

endpackage

FILE: rtl/fpga_config_restart_sequencer.sv
// fpga_config_restart_sequencer: program / init / done pin restart sequencer
// depends on fcrs_pkg for the phase enum, result record and register map
//
// usage: each request on the input channel (in_valid / in_stall) is either a
// one millisecond tick carrying the sampled INIT_B and DONE pins, or a start
// carrying the set-up status. every request produces exactly one result on
// the output channel (out_valid / out_stall) with the pin controls, the
// phase code, attempt counters and the run outcome after that request.
// the result of an accepted request is registered into the output buffer and
// offered once older results have left. throughput is one request per cycle while
// in_stall is low; the sequencer state takes a single next-state pass per request.
// results go through a two-entry output buffer, so a request is still taken
// while one result waits; in_stall rises only when both entries are full.
// registers are written on the cfg channel (cfg_valid / cfg_ready, always
// ready), index 0..6 in the register map, other indexes are dropped. write
// them while no request is in flight; changes act at once.
// reset returns all registers to their defaults, the sequencer to idle with
// counters cleared and the mux disabled, and empties the output buffer.
module fpga_config_restart_sequencer #(
    parameter int TIMER_BITS = fcrs_pkg::TIMER_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            req_type,
    input  logic                            setup_ok,
    input  logic                            init_pin,
    input  logic                            done_pin,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            program_asserted,
    output logic                            mux_on,
    output logic [3:0]                      phase_code,
    output logic [fcrs_pkg::COUNT_W-1:0]    attempts_used,
    output logic [fcrs_pkg::COUNT_W-1:0]    init_low_count,
    output logic [1:0]                      outcome,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fcrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fcrs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fcrs_pkg::*;

    // compare width covers both the timer and the widest limit
    localparam int CMP_W = (TIMER_BITS > LIMIT_W) ? TIMER_BITS : LIMIT_W;

    // configuration registers
    logic [LIMIT_W-1:0] init_wait_reg;
    logic [LIMIT_W-1:0] done_wait_reg;
    logic [COUNT_W-1:0] attempt_lim_reg;
    logic [TICKS_W-1:0] hold_reg;
    logic [TICKS_W-1:0] pre_settle_reg;
    logic [TICKS_W-1:0] done_settle_reg;
    logic [TICKS_W-1:0] backoff_reg;

    // sequencer state
    phase_t                phase_reg, phase_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic [COUNT_W-1:0]    attempt_reg, attempt_next;
    logic [COUNT_W-1:0]    init_low_reg, init_low_next;
    logic                  mux_reg, mux_next;
    outcome_t              outcome_reg, outcome_next;

    // output buffer
    result_t    buf_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    result_t    result;

    logic                  in_accept;
    logic                  out_accept;
    logic                  running;
    logic [TIMER_BITS-1:0] timer_inc;
    logic [TICKS_W-1:0]    delay_lim;
    logic [LIMIT_W-1:0]    wait_lim;
    logic                  delay_done;
    logic                  wait_to;
    logic [COUNT_W-1:0]    lim_attempts;
    logic [COUNT_W-1:0]    attempt_bump;

    assign cfg_ready  = 1'b1;
    assign in_stall   = (count_reg == 2'd2);
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = (count_reg != 2'd0);
    assign out_accept = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_wait_reg   <= INIT_WAIT_RST;
            done_wait_reg   <= DONE_WAIT_RST;
            attempt_lim_reg <= ATTEMPT_RST;
            hold_reg        <= HOLD_RST;
            pre_settle_reg  <= PRE_SETTLE_RST;
            done_settle_reg <= DONE_SETTLE_RST;
            backoff_reg     <= BACKOFF_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_INIT_WAIT:   init_wait_reg   <= cfg_data;
                REG_DONE_WAIT:   done_wait_reg   <= cfg_data;
                REG_ATTEMPTS:    attempt_lim_reg <= cfg_data[COUNT_W-1:0];
                REG_HOLD:        hold_reg        <= cfg_data[TICKS_W-1:0];
                REG_PRE_SETTLE:  pre_settle_reg  <= cfg_data[TICKS_W-1:0];
                REG_DONE_SETTLE: done_settle_reg <= cfg_data[TICKS_W-1:0];
                REG_BACKOFF:     backoff_reg     <= cfg_data[TICKS_W-1:0];
                default:         ;
            endcase
        end
    end

    // per-phase limits and timer compares
    assign timer_inc = (&timer_reg) ? timer_reg : timer_reg + 1'b1;

    assign delay_lim = (phase_reg == PH_SETTLE)      ? pre_settle_reg  :
                       (phase_reg == PH_HOLD)        ? hold_reg        :
                       (phase_reg == PH_DONE_SETTLE) ? done_settle_reg :
                                                       backoff_reg;
    assign wait_lim  = (phase_reg == PH_WAIT_DONE) ? done_wait_reg : init_wait_reg;

    // saturated timer equals the clamped limit, so reaching all ones also ends the count
    assign delay_done = (CMP_W'(timer_inc) >= CMP_W'(delay_lim)) || (&timer_inc);
    assign wait_to    = (CMP_W'(timer_reg) >= CMP_W'(wait_lim)) || (&timer_reg);

    assign lim_attempts = (attempt_lim_reg == '0) ? COUNT_W'(1) : attempt_lim_reg;
    assign attempt_bump = (&attempt_reg) ? attempt_reg : attempt_reg + 1'b1;

    always_comb
    begin
        case (phase_reg) inside
            PH_SETTLE, PH_RESET_WAIT, PH_HOLD, PH_WAIT_INIT, PH_WAIT_DONE,
            PH_DONE_SETTLE, PH_INIT_TO, PH_DONE_TO: running = 1'b1;
            default:                                running = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            timer_reg    <= '0;
            attempt_reg  <= '0;
            init_low_reg <= '0;
            mux_reg      <= 1'b0;
            outcome_reg  <= OUT_RUNNING;
        end
        else if (in_accept)
        begin
            phase_reg    <= phase_next;
            timer_reg    <= timer_next;
            attempt_reg  <= attempt_next;
            init_low_reg <= init_low_next;
            mux_reg      <= mux_next;
            outcome_reg  <= outcome_next;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        timer_next    = timer_reg;
        attempt_next  = attempt_reg;
        init_low_next = init_low_reg;
        mux_next      = mux_reg;
        outcome_next  = outcome_reg;

        if (req_t'(req_type) == REQ_START)
        begin
            // a start during a run is dropped
            if (!running)
            begin
                attempt_next  = '0;
                init_low_next = '0;
                timer_next    = '0;
                if (setup_ok)
                begin
                    mux_next     = 1'b1;
                    outcome_next = OUT_RUNNING;
                    phase_next   = PH_SETTLE;
                end
                else
                begin
                    mux_next     = 1'b0;
                    outcome_next = OUT_SETUP_ERR;
                    phase_next   = PH_SETUP_ERR;
                end
            end
        end
        else
        begin
            unique case (phase_reg) inside
                PH_SETTLE:
                begin
                    timer_next = timer_inc;
                    if (delay_done)
                    begin
                        attempt_next = attempt_bump;
                        phase_next   = PH_RESET_WAIT;
                        timer_next   = '0;
                    end
                end
                PH_RESET_WAIT:
                begin
                    if (!init_pin)
                    begin
                        init_low_next = (&init_low_reg) ? init_low_reg : init_low_reg + 1'b1;
                        phase_next    = PH_HOLD;
                        timer_next    = '0;
                    end
                    else if (wait_to)
                    begin
                        phase_next = PH_INIT_TO;
                        timer_next = '0;
                    end
                    else
                    begin
                        timer_next = timer_inc;
                    end
                end
                PH_HOLD:
                begin
                    timer_next = timer_inc;
                    if (delay_done)
                    begin
                        phase_next = PH_WAIT_INIT;
                        timer_next = '0;
                    end
                end
                PH_WAIT_INIT:
                begin
                    if (init_pin)
                    begin
                        phase_next = PH_WAIT_DONE;
                        timer_next = '0;
                    end
                    else if (wait_to)
                    begin
                        phase_next = PH_INIT_TO;
                        timer_next = '0;
                    end
                    else
                    begin
                        timer_next = timer_inc;
                    end
                end
                PH_WAIT_DONE:
                begin
                    if (done_pin)
                    begin
                        phase_next = PH_DONE_SETTLE;
                        timer_next = '0;
                    end
                    else if (wait_to)
                    begin
                        phase_next = PH_DONE_TO;
                        timer_next = '0;
                    end
                    else
                    begin
                        timer_next = timer_inc;
                    end
                end
                PH_DONE_SETTLE:
                begin
                    timer_next = timer_inc;
                    if (delay_done)
                    begin
                        phase_next   = PH_SUCCESS;
                        timer_next   = '0;
                        mux_next     = 1'b1;
                        outcome_next = OUT_SUCCESS;
                    end
                end
                PH_INIT_TO, PH_DONE_TO:
                begin
                    timer_next = timer_inc;
                    if (delay_done)
                    begin
                        timer_next = '0;
                        if (attempt_reg < lim_attempts)
                        begin
                            attempt_next = attempt_bump;
                            phase_next   = PH_RESET_WAIT;
                        end
                        else
                        begin
                            phase_next   = (phase_reg == PH_INIT_TO) ? PH_FAIL_INIT
                                                                     : PH_FAIL_DONE;
                            mux_next     = 1'b1;
                            outcome_next = OUT_TIMEOUT;
                        end
                    end
                end
                default: ;
            endcase
        end

        result.program_asserted = (phase_next == PH_RESET_WAIT) || (phase_next == PH_HOLD);
        result.mux_on           = mux_next;
        result.phase_code       = phase_to_code(phase_next);
        result.attempts_used    = attempt_next;
        result.init_low_count   = init_low_next;
        result.outcome          = outcome_next;
    end

    // two-entry result buffer
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            buf_reg[wr_ptr_reg] <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (in_accept)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (out_accept)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (in_accept && !out_accept)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (out_accept && !in_accept)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    assign program_asserted = buf_reg[rd_ptr_reg].program_asserted;
    assign mux_on           = buf_reg[rd_ptr_reg].mux_on;
    assign phase_code       = buf_reg[rd_ptr_reg].phase_code;
    assign attempts_used    = buf_reg[rd_ptr_reg].attempts_used;
    assign init_low_count   = buf_reg[rd_ptr_reg].init_low_count;
    assign outcome          = buf_reg[rd_ptr_reg].outcome;

    // buffer never holds more than two results
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    // a failed set-up start from a stopped state ends in the error phase with the mux off
    a_setup_err: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && req_type && !setup_ok && !running)
        |=> (phase_reg == PH_SETUP_ERR) && !mux_reg && (outcome_reg == OUT_SETUP_ERR))
        else $error("set-up failure not reported");

    // success always comes with the mux on and a success outcome
    a_success: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SUCCESS) |-> mux_reg && (outcome_reg == OUT_SUCCESS))
        else $error("success phase without success outcome");

    // the timer is idle whenever no run is active
    a_timer_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !running |-> (timer_reg == '0))
        else $error("timer running outside a run");

    // a full buffer keeps stalling until a result leaves
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) && out_stall |=> in_stall)
        else $error("buffer freed without a result leaving");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for fpga_config_restart_sequencer
// depends on fcrs_pkg and the sequencer rtl; predicts each status result and
// compares it with the output channel under random idling and stalls
module tb;
    import fcrs_pkg::*;

    localparam int SEQ_TIMER_BITS = TIMER_BITS_DEF;
    localparam logic [31:0] TIMER_MAX = (32'd1 << SEQ_TIMER_BITS) - 32'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
    localparam int HOLD_CYCLES = 60;
    localparam int QUIET_LIMIT = 2000;

    typedef enum { WAIT_PENDING, WAIT_MATCHED, WAIT_EXPIRED } wait_status_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic req_type = 1'b0;
    logic setup_ok = 1'b0;
    logic init_pin = 1'b0;
    logic done_pin = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic program_asserted;
    logic mux_on;
    logic [3:0] phase_code;
    logic [COUNT_W-1:0] attempts_used;
    logic [COUNT_W-1:0] init_low_count;
    logic [1:0] outcome;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // register copies as the sequencer holds them
    logic [LIMIT_W-1:0] cfg_init_wait = INIT_WAIT_RST;
    logic [LIMIT_W-1:0] cfg_done_wait = DONE_WAIT_RST;
    logic [COUNT_W-1:0] cfg_attempts = ATTEMPT_RST;
    logic [TICKS_W-1:0] cfg_hold = HOLD_RST;
    logic [TICKS_W-1:0] cfg_pre_settle = PRE_SETTLE_RST;
    logic [TICKS_W-1:0] cfg_done_settle = DONE_SETTLE_RST;
    logic [TICKS_W-1:0] cfg_backoff = BACKOFF_RST;

    // sequencer state mirror
    phase_t seq_phase = PH_IDLE;
    logic [SEQ_TIMER_BITS-1:0] seq_timer = '0;
    logic [COUNT_W-1:0] seq_attempts = '0;
    logic [COUNT_W-1:0] seq_init_lows = '0;
    logic seq_mux = 1'b0;
    outcome_t seq_outcome = OUT_RUNNING;

    result_t expected_status[$];
    result_t want;
    int mismatches = 0;
    int idle_pct = 32;
    int hold_asked = 0;
    int hold_granted = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    fpga_config_restart_sequencer i_dut (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] clamp_limit(input logic [31:0] lim);
        return (lim > TIMER_MAX) ? TIMER_MAX : lim;
    endfunction

    function automatic void bump_timer();
        if (seq_timer < TIMER_MAX)
            seq_timer = seq_timer + 1'b1;
    endfunction

    function automatic bit delay_elapsed(input logic [31:0] lim);
        bump_timer();
        return seq_timer >= clamp_limit(lim);
    endfunction

    function automatic wait_status_t pin_wait(input logic matched, input logic [31:0] lim);
        if (matched)
            return WAIT_MATCHED;
        if (seq_timer >= clamp_limit(lim))
            return WAIT_EXPIRED;
        bump_timer();
        return WAIT_PENDING;
    endfunction

    function automatic void enter_phase(input phase_t ph);
        seq_phase = ph;
        seq_timer = '0;
    endfunction

    function automatic void begin_attempt();
        if (seq_attempts < 4'd15)
            seq_attempts = seq_attempts + 1'b1;
        enter_phase(PH_RESET_WAIT);
    endfunction

    function automatic bit seq_running();
        return seq_phase inside {PH_SETTLE, PH_RESET_WAIT, PH_HOLD, PH_WAIT_INIT,
                                 PH_WAIT_DONE, PH_DONE_SETTLE, PH_INIT_TO, PH_DONE_TO};
    endfunction

    function automatic phase_code_t reported_code(input phase_t ph);
        case (ph) inside
            PH_SETTLE:                    return CODE_SETTLE;
            PH_RESET_WAIT, PH_HOLD:       return CODE_RESET;
            PH_WAIT_INIT:                 return CODE_WAIT_INIT;
            PH_WAIT_DONE, PH_DONE_SETTLE: return CODE_WAIT_DONE;
            PH_INIT_TO, PH_FAIL_INIT:     return CODE_INIT_TO;
            PH_DONE_TO, PH_FAIL_DONE:     return CODE_DONE_TO;
            PH_SUCCESS:                   return CODE_SUCCESS;
            PH_SETUP_ERR:                 return CODE_SETUP_ERR;
            default:                      return CODE_IDLE;
        endcase
    endfunction

    function automatic result_t advance_sequencer(input req_t kind, input logic ok,
                                                  input logic init_hi, input logic done_hi);
        result_t res;
        wait_status_t ws;
        logic [COUNT_W-1:0] attempt_cap;
        attempt_cap = (cfg_attempts == '0) ? 4'd1 : cfg_attempts;
        if (kind == REQ_START)
        begin
            // a start during a run is dropped
            if (!seq_running())
            begin
                seq_attempts = '0;
                seq_init_lows = '0;
                seq_timer = '0;
                if (ok)
                begin
                    seq_mux = 1'b1;
                    seq_outcome = OUT_RUNNING;
                    seq_phase = PH_SETTLE;
                end
                else
                begin
                    seq_mux = 1'b0;
                    seq_outcome = OUT_SETUP_ERR;
                    seq_phase = PH_SETUP_ERR;
                end
            end
        end
        else
        begin
            case (seq_phase) inside
                PH_SETTLE:
                begin
                    if (delay_elapsed(32'(cfg_pre_settle)))
                        begin_attempt();
                end
                PH_RESET_WAIT:
                begin
                    ws = pin_wait(!init_hi, 32'(cfg_init_wait));
                    if (ws == WAIT_MATCHED)
                    begin
                        if (seq_init_lows < 4'd15)
                            seq_init_lows = seq_init_lows + 1'b1;
                        enter_phase(PH_HOLD);
                    end
                    else if (ws == WAIT_EXPIRED)
                        enter_phase(PH_INIT_TO);
                end
                PH_HOLD:
                begin
                    if (delay_elapsed(32'(cfg_hold)))
                        enter_phase(PH_WAIT_INIT);
                end
                PH_WAIT_INIT:
                begin
                    ws = pin_wait(init_hi, 32'(cfg_init_wait));
                    if (ws == WAIT_MATCHED)
                        enter_phase(PH_WAIT_DONE);
                    else if (ws == WAIT_EXPIRED)
                        enter_phase(PH_INIT_TO);
                end
                PH_WAIT_DONE:
                begin
                    ws = pin_wait(done_hi, 32'(cfg_done_wait));
                    if (ws == WAIT_MATCHED)
                        enter_phase(PH_DONE_SETTLE);
                    else if (ws == WAIT_EXPIRED)
                        enter_phase(PH_DONE_TO);
                end
                PH_DONE_SETTLE:
                begin
                    if (delay_elapsed(32'(cfg_done_settle)))
                    begin
                        enter_phase(PH_SUCCESS);
                        seq_mux = 1'b1;
                        seq_outcome = OUT_SUCCESS;
                    end
                end
                PH_INIT_TO, PH_DONE_TO:
                begin
                    if (delay_elapsed(32'(cfg_backoff)))
                    begin
                        if (seq_attempts < attempt_cap)
                            begin_attempt();
                        else
                        begin
                            // last attempt gone: keep the timeout code, mux stays on
                            if (seq_phase == PH_INIT_TO)
                                enter_phase(PH_FAIL_INIT);
                            else
                                enter_phase(PH_FAIL_DONE);
                            seq_mux = 1'b1;
                            seq_outcome = OUT_TIMEOUT;
                        end
                    end
                end
                default:
                    ;
            endcase
        end
        res.program_asserted = (seq_phase == PH_RESET_WAIT) || (seq_phase == PH_HOLD);
        res.mux_on = seq_mux;
        res.phase_code = reported_code(seq_phase);
        res.attempts_used = seq_attempts;
        res.init_low_count = seq_init_lows;
        res.outcome = seq_outcome;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("%0t mismatch %s: got %0d, want %0d", $time, what, got, exp_val);
        mismatches++;
    endtask

    // results are taken at the edge after a negedge that shows valid and no stall
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_status.size() == 0)
                report_mismatch("status with no request pending", 32'(phase_code), 32'd0);
            else
            begin
                want = expected_status.pop_front();
                if (program_asserted !== want.program_asserted)
                    report_mismatch("program_asserted", 32'(program_asserted),
                                    32'(want.program_asserted));
                if (mux_on !== want.mux_on)
                    report_mismatch("mux_on", 32'(mux_on), 32'(want.mux_on));
                if (phase_code !== want.phase_code)
                    report_mismatch("phase_code", 32'(phase_code), 32'(want.phase_code));
                if (attempts_used !== want.attempts_used)
                    report_mismatch("attempts_used", 32'(attempts_used),
                                    32'(want.attempts_used));
                if (init_low_count !== want.init_low_count)
                    report_mismatch("init_low_count", 32'(init_low_count),
                                    32'(want.init_low_count));
                if (outcome !== want.outcome)
                    report_mismatch("outcome", 32'(outcome), 32'(want.outcome));
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // receiver side: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_asked != hold_granted)
        begin
            hold_granted = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    task automatic send_request(input req_t kind, input logic ok, input logic init_hi,
                                input logic done_hi);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        setup_ok <= ok;
        init_pin <= init_hi;
        done_pin <= done_hi;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        expected_status.push_back(advance_sequencer(kind, ok, init_hi, done_hi));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        case (idx)
            REG_INIT_WAIT:   cfg_init_wait = value[LIMIT_W-1:0];
            REG_DONE_WAIT:   cfg_done_wait = value[LIMIT_W-1:0];
            REG_ATTEMPTS:    cfg_attempts = value[COUNT_W-1:0];
            REG_HOLD:        cfg_hold = value[TICKS_W-1:0];
            REG_PRE_SETTLE:  cfg_pre_settle = value[TICKS_W-1:0];
            REG_DONE_SETTLE: cfg_done_settle = value[TICKS_W-1:0];
            REG_BACKOFF:     cfg_backoff = value[TICKS_W-1:0];
            default:         ;
        endcase
    endtask

    // unused index goes first and must be dropped; narrow registers get junk upper bits
    task automatic set_config(input logic [LIMIT_W-1:0] init_lim,
                              input logic [LIMIT_W-1:0] done_lim,
                              input logic [COUNT_W-1:0] attempts,
                              input logic [TICKS_W-1:0] hold,
                              input logic [TICKS_W-1:0] pre_settle,
                              input logic [TICKS_W-1:0] done_settle,
                              input logic [TICKS_W-1:0] backoff);
        logic [CFG_DATA_W-1:0] pad;
        drain_results();
        pad = CFG_DATA_W'($urandom);
        write_register(CFG_SPARE_IDX, pad);
        write_register(REG_INIT_WAIT, init_lim);
        write_register(REG_DONE_WAIT, done_lim);
        pad = CFG_DATA_W'($urandom);
        write_register(REG_ATTEMPTS, {pad[8:0], attempts});
        pad = CFG_DATA_W'($urandom);
        write_register(REG_HOLD, {pad[2:0], hold});
        pad = CFG_DATA_W'($urandom);
        write_register(REG_PRE_SETTLE, {pad[2:0], pre_settle});
        pad = CFG_DATA_W'($urandom);
        write_register(REG_DONE_SETTLE, {pad[2:0], done_settle});
        pad = CFG_DATA_W'($urandom);
        write_register(REG_BACKOFF, {pad[2:0], backoff});
        cfg_valid <= 1'b0;
    endtask

    // mostly pin behavior that walks the sequence forward, with some noise
    task automatic run_mixed_traffic(input int count);
        int roll;
        logic ini;
        logic don;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            ini = 1'($urandom_range(0, 1));
            don = 1'($urandom_range(0, 1));
            if (roll < 4)
                send_request(req_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), ini, don);
            else if (!seq_running())
            begin
                if (roll < 70)
                    send_request(REQ_START, $urandom_range(0, 9) != 0, ini, don);
                else
                    send_request(REQ_TICK, 1'($urandom_range(0, 1)), ini, don);
            end
            else if (roll < 7)
                send_request(REQ_START, 1'($urandom_range(0, 1)), ini, don);
            else
            begin
                case (seq_phase)
                    PH_RESET_WAIT: ini = ($urandom_range(0, 99) < 35);
                    PH_WAIT_INIT:  ini = ($urandom_range(0, 99) < 70);
                    PH_WAIT_DONE:  don = ($urandom_range(0, 99) < 60);
                    default:       ;
                endcase
                send_request(REQ_TICK, 1'($urandom_range(0, 1)), ini, don);
            end
        end
    endtask

    task automatic test_idle_ticks();
        send_request(REQ_TICK, 1'b1, 1'b0, 1'b0);
        send_request(REQ_TICK, 1'b0, 1'b1, 1'b1);
    endtask

    // shortest settings: zero delays, limit of one, zero attempts meaning one
    task automatic test_directed_paths();
        set_config(13'd1, 13'd1, 4'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        send_request(REQ_START, 1'b1, 1'b1, 1'b0);
        send_request(REQ_START, 1'b1, 1'b0, 1'b1);
        send_request(REQ_START, 1'b0, 1'b1, 1'b1);
        send_request(REQ_TICK, 1'b0, 1'b1, 1'b0);
        send_request(REQ_TICK, 1'b1, 1'b0, 1'b0);
        send_request(REQ_TICK, 1'b0, 1'b0, 1'b1);
        send_request(REQ_TICK, 1'b0, 1'b1, 1'b0);
        send_request(REQ_TICK, 1'b0, 1'b1, 1'b1);
        send_request(REQ_TICK, 1'b1, 1'b1, 1'b1);
        send_request(REQ_TICK, 1'b0, 1'b0, 1'b0);
        // init timeout on the only attempt
        send_request(REQ_START, 1'b1, 1'b0, 1'b0);
        send_request(REQ_TICK, 1'b0, 1'b1, 1'b0);
        send_request(REQ_TICK, 1'b0, 1'b1, 1'b0);
        send_request(REQ_TICK, 1'b0, 1'b1, 1'b1);
        send_request(REQ_TICK, 1'b0, 1'b1, 1'b0);
        // done timeout
        send_request(REQ_START, 1'b1, 1'b1, 1'b1);
        send_request(REQ_TICK, 1'b0, 1'b1, 1'b0);
        send_request(REQ_TICK, 1'b0, 1'b0, 1'b0);
        send_request(REQ_TICK, 1'b0, 1'b0, 1'b0);
        send_request(REQ_TICK, 1'b0, 1'b1, 1'b0);
        send_request(REQ_TICK, 1'b0, 1'b1, 1'b0);
        send_request(REQ_TICK, 1'b0, 1'b1, 1'b0);
        send_request(REQ_TICK, 1'b0, 1'b1, 1'b0);
        // setup failure after a finished run clears the counters
        send_request(REQ_START, 1'b0, 1'b0, 1'b1);
    endtask

    task automatic test_limit_extremes();
        set_config(13'h1FFF, 13'h1FFF, 4'hF, 10'd0, 10'd1, 10'd0, 10'd2);
        run_mixed_traffic(150);
        set_config(13'd2, 13'd3, 4'd2, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
        run_mixed_traffic(80);
    endtask

    task automatic test_random_settings();
        for (int s = 0; s < 4; s++)
        begin
            set_config(LIMIT_W'($urandom_range(0, 6)), LIMIT_W'($urandom_range(0, 8)),
                       COUNT_W'($urandom_range(0, 4)), TICKS_W'($urandom_range(0, 4)),
                       TICKS_W'($urandom_range(0, 3)), TICKS_W'($urandom_range(0, 4)),
                       TICKS_W'($urandom_range(0, 3)));
            run_mixed_traffic(150);
        end
    endtask

    task automatic test_backpressure();
        idle_pct = 0;
        run_mixed_traffic(100);
        // receiver holds off while requests keep coming, so the input stalls
        hold_asked = hold_asked + 1;
        run_mixed_traffic(40);
        idle_pct = 32;
        run_mixed_traffic(30);
        drain_results();
        run_mixed_traffic(30);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_ticks();
        test_directed_paths();
        test_limit_extremes();
        test_random_settings();
        test_backpressure();
        drain_results();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && expected_status.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
